// ===== rtl/mvpm_pkg.sv =====
package mvpm_pkg;

    localparam int VOICES_DEF        = 8;
    localparam int SAMPLE_FRAMES_DEF = 65536;

    // Field widths of the command and result words
    localparam int OP_W     = 3;
    localparam int VSEL_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 17;
    localparam int POS_W    = 16;
    localparam int VOL_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int MASK_W   = 8;

    // Counter width that covers the largest voice count plus one
    localparam int CNT_MAX_W = 6;

    // Gain arithmetic: gain = vol + (vol >= 128), product scaled by 1/256
    localparam int GAIN_W      = VOL_W + 1;
    localparam int GAIN_SHIFT  = 8;
    localparam int PROD_W      = SAMPLE_W + GAIN_SHIFT;
    localparam int PROD_FULL_W = SAMPLE_W + GAIN_W + 1;

    localparam logic [LEN_W-1:0] LEN_MAX = 17'd65536;

    localparam int SAMPLE_MIN = -32768;
    localparam int SAMPLE_MAX = 32767;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 3'd0,
        OP_PLAY     = 3'd1,
        OP_SET_VOL  = 3'd2,
        OP_STOP     = 3'd3,
        OP_TICK     = 3'd4,
        OP_STOP_ALL = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_WRITE,
        S_PLAY_SCAN,
        S_SIMPLE,
        S_TICK_SCAN,
        S_TICK_MUL_L,
        S_TICK_MUL_R,
        S_TICK_ACC_R,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic mul_right;
        logic acc_en;
        logic acc_right;
    } t_mac_ctrl;

    // One-hot finished bit for a voice slot; slots past the mask width are dropped
    function automatic logic [MASK_W-1:0] fin_bit(input logic [CNT_MAX_W-1:0] idx);
        logic [MASK_W-1:0] m;
        m = '0;
        if (idx < CNT_MAX_W'(MASK_W)) begin
            m[idx[2:0]] = 1'b1;
        end
        return m;
    endfunction

endpackage

// ===== rtl/mvpm_in_if.sv =====
interface mvpm_in_if;
    logic                                valid;
    logic                                ready;
    logic        [mvpm_pkg::OP_W-1:0]     op;
    logic        [mvpm_pkg::VSEL_W-1:0]   voice;
    logic        [mvpm_pkg::ADDR_W-1:0]   address;
    logic        [mvpm_pkg::LEN_W-1:0]    sound_length;
    logic        [mvpm_pkg::VOL_W-1:0]    volume;
    logic                                repeat_req;
    logic signed [mvpm_pkg::SAMPLE_W-1:0] left_in;
    logic signed [mvpm_pkg::SAMPLE_W-1:0] right_in;

    modport source (
        output valid, op, voice, address, sound_length, volume, repeat_req, left_in, right_in,
        input  ready
    );
    modport sink (
        input  valid, op, voice, address, sound_length, volume, repeat_req, left_in, right_in,
        output ready
    );
endinterface

// ===== rtl/mvpm_out_if.sv =====
interface mvpm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mvpm_pkg::SAMPLE_W-1:0] left_out;
    logic signed [mvpm_pkg::SAMPLE_W-1:0] right_out;
    logic        [mvpm_pkg::MASK_W-1:0]   finished_mask;
    logic        [mvpm_pkg::VSEL_W-1:0]   handle;
    logic                                no_free_voice;

    modport source (
        output valid, left_out, right_out, finished_mask, handle, no_free_voice,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, finished_mask, handle, no_free_voice,
        output ready
    );
endinterface

// ===== rtl/mvpm_sample_mem.sv =====
module mvpm_sample_mem #(
    parameter int SAMPLE_FRAMES = mvpm_pkg::SAMPLE_FRAMES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(SAMPLE_FRAMES)-1:0]   i_waddr,
    input  logic [mvpm_pkg::FRAME_W-1:0]       i_wdata,
    input  logic                               i_re,
    input  logic [$clog2(SAMPLE_FRAMES)-1:0]   i_raddr,
    output logic [mvpm_pkg::FRAME_W-1:0]       o_rdata
);

    logic [mvpm_pkg::FRAME_W-1:0] r_mem [SAMPLE_FRAMES];
    logic [mvpm_pkg::FRAME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mvpm_addr_mod.sv =====
// Reduce a frame address modulo the memory depth, one compare-subtract per cycle.
module mvpm_addr_mod #(
    parameter int SAMPLE_FRAMES = mvpm_pkg::SAMPLE_FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [mvpm_pkg::ADDR_W-1:0]       i_value,
    output logic                              o_done,
    output logic [$clog2(SAMPLE_FRAMES)-1:0]  o_rem
);

    localparam int MAW   = $clog2(SAMPLE_FRAMES);
    localparam int MAXQ  = ((1 << mvpm_pkg::ADDR_W) - 1) / SAMPLE_FRAMES;
    localparam int STEPS = (MAXQ == 0) ? 1 : $clog2(MAXQ + 1);
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int FW    = $clog2(SAMPLE_FRAMES + 1);
    localparam int DW    = ((FW > mvpm_pkg::ADDR_W) ? FW : mvpm_pkg::ADDR_W) + 1;
    localparam logic [DW-1:0] DIV_INIT  = DW'(SAMPLE_FRAMES) << (STEPS - 1);
    localparam logic [SW-1:0] STEP_LAST = SW'(STEPS - 1);

    logic          r_busy;
    logic [SW-1:0] r_step;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DW'(i_value);
            r_div  <= DIV_INIT;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
            end
            r_div  <= r_div >> 1;
            r_step <= r_step + SW'(1);
        end
    end

    // Remainder is final in the cycle after done
    assign o_done = r_busy && (r_step == STEP_LAST);
    assign o_rem  = r_rem[MAW-1:0];

endmodule

// ===== rtl/mvpm_mac.sv =====
// Shared multiply-accumulate: one multiplier, product register, left/right sums.
module mvpm_mac #(
    parameter int VOICES = mvpm_pkg::VOICES_DEF
) (
    input  logic                                i_clk,
    input  mvpm_pkg::t_mac_ctrl                 i_ctrl,
    input  logic        [mvpm_pkg::FRAME_W-1:0]  i_frame,
    input  logic        [mvpm_pkg::VOL_W-1:0]    i_volume,
    output logic signed [mvpm_pkg::SAMPLE_W-1:0] o_left,
    output logic signed [mvpm_pkg::SAMPLE_W-1:0] o_right
);

    localparam int SW    = mvpm_pkg::SAMPLE_W;
    localparam int PW    = mvpm_pkg::PROD_W;
    localparam int ACC_W = SW + $clog2(VOICES) + 1;
    localparam logic signed [ACC_W-1:0] LIM_LO = ACC_W'(mvpm_pkg::SAMPLE_MIN);
    localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(mvpm_pkg::SAMPLE_MAX);
    localparam logic [PW-1:0] ROUND = PW'((1 << mvpm_pkg::GAIN_SHIFT) - 1);

    logic        [mvpm_pkg::GAIN_W-1:0]      w_gain;
    logic signed [SW-1:0]                    w_sample;
    logic signed [mvpm_pkg::PROD_FULL_W-1:0] w_prod_full;
    logic signed [PW-1:0]                    r_prod;
    logic        [PW-1:0]                    w_round;
    logic signed [SW-1:0]                    w_scaled;
    logic signed [ACC_W-1:0]                 r_acc_l;
    logic signed [ACC_W-1:0]                 r_acc_r;

    function automatic logic signed [SW-1:0] clamp(input logic signed [ACC_W-1:0] a);
        logic signed [SW-1:0] c;
        if (a < LIM_LO) begin
            c = LIM_LO[SW-1:0];
        end else if (a > LIM_HI) begin
            c = LIM_HI[SW-1:0];
        end else begin
            c = a[SW-1:0];
        end
        return c;
    endfunction

    assign w_gain      = {1'b0, i_volume} + mvpm_pkg::GAIN_W'(i_volume[mvpm_pkg::VOL_W-1]);
    assign w_sample    = i_ctrl.mul_right ? i_frame[mvpm_pkg::FRAME_W-1:SW] : i_frame[SW-1:0];
    assign w_prod_full = w_sample * $signed({1'b0, w_gain});

    // Truncate toward zero: bias negative products before the arithmetic shift
    assign w_round  = r_prod + (r_prod[PW-1] ? ROUND : '0);
    assign w_scaled = w_round[PW-1:mvpm_pkg::GAIN_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod_full[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (i_ctrl.acc_en) begin
            if (i_ctrl.acc_right) begin
                r_acc_r <= r_acc_r + ACC_W'(w_scaled);
            end else begin
                r_acc_l <= r_acc_l + ACC_W'(w_scaled);
            end
        end
    end

    assign o_left  = clamp(r_acc_l);
    assign o_right = clamp(r_acc_r);

endmodule

// ===== rtl/multi_voice_pcm_mixer.sv =====
// Multi-voice stereo PCM mixer.
// i_req carries one command word per handshake (valid/ready): write a stereo
// frame to sample memory, play, set volume, stop, stop all, or tick. Every
// accepted word yields exactly one word on o_rsp. A tick word returns the
// clamped left/right mix of all active voices and the mask of voices that
// ran off the end of a one-shot sound; play returns the slot handle or
// no_free_voice; stop and stop all return the mask of voices they halted.
// Commands run one at a time through a small sequencer that steps a shared
// multiply-accumulate over the voice slots. Write and play first reduce the
// address modulo the memory depth: one compare-subtract step when the memory
// covers the full 16-bit address, one step per quotient bit otherwise. Play
// then scans for the lowest free slot. A tick scans every slot and, for each
// active voice, does one memory read and two products on a single multiplier.
// Set volume, stop and stop all act in their own sequencer state; unused
// codes go straight to the result.
// i_req.ready is high only while the sequencer is idle. The result sits in
// an output register; while o_rsp is stalled the next command is still
// accepted and runs, then waits for the register to drain.
// Reset frees all voices; memory and voice settings must be written first.
module multi_voice_pcm_mixer #(
    parameter int VOICES        = mvpm_pkg::VOICES_DEF,
    parameter int SAMPLE_FRAMES = mvpm_pkg::SAMPLE_FRAMES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvpm_in_if.sink    i_req,
    mvpm_out_if.source o_rsp
);

    localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW  = $clog2(VOICES + 1);
    localparam int MAW = $clog2(SAMPLE_FRAMES);
    localparam int SW  = mvpm_pkg::SAMPLE_W;
    localparam int LW  = mvpm_pkg::LEN_W;
    localparam int PSW = mvpm_pkg::POS_W;
    localparam int MW  = mvpm_pkg::MASK_W;
    localparam int HW  = mvpm_pkg::VSEL_W;
    localparam logic [MAW-1:0] PTR_LAST = MAW'(SAMPLE_FRAMES - 1);

    mvpm_pkg::t_state r_state, n_state;

    // Latched command word
    logic [mvpm_pkg::OP_W-1:0]   r_op;
    logic [HW-1:0]               r_vsel;
    logic [LW-1:0]               r_len;
    logic [mvpm_pkg::VOL_W-1:0]  r_vol;
    logic                        r_rep;
    logic [SW-1:0]               r_lin;
    logic [SW-1:0]               r_rin;

    // Per-command progress and pending result
    logic [CW-1:0]  r_cnt;
    logic [MW-1:0]  r_fin;
    logic [HW-1:0]  r_handle;
    logic           r_nofree;
    logic           r_is_tick;

    // Output register
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_left;
    logic signed [SW-1:0] r_out_right;
    logic [MW-1:0]        r_out_fin;
    logic [HW-1:0]        r_out_handle;
    logic                 r_out_nofree;

    // Voice slots
    logic [VOICES-1:0]          r_active;
    logic [MAW-1:0]             r_start [VOICES];
    logic [MAW-1:0]             r_ptr   [VOICES];
    logic [PSW-1:0]             r_pos   [VOICES];
    logic [LW-1:0]              r_len_v [VOICES];
    logic [mvpm_pkg::VOL_W-1:0] r_vol_v [VOICES];
    logic                       r_rep_v [VOICES];

    logic                     w_in_ready;
    logic                     w_accept;
    logic                     w_mod_start;
    logic                     w_mod_done;
    logic [MAW-1:0]           w_mod_rem;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic [mvpm_pkg::FRAME_W-1:0] w_mem_rdata;
    mvpm_pkg::t_mac_ctrl      w_mac_ctrl;
    logic signed [SW-1:0]     w_mix_left;
    logic signed [SW-1:0]     w_mix_right;

    logic [VW-1:0] w_idx;
    logic [VW-1:0] w_v_idx;
    logic          w_v_ok;
    logic          w_cnt_end;
    logic [LW-1:0] w_pos_inc;
    logic          w_wrap;
    logic [MAW-1:0] w_ptr_next;
    logic [LW-1:0] w_len_fix;

    logic w_out_load;
    logic w_cnt_inc;
    logic w_claim;
    logic w_play_full;
    logic w_voice_step;
    logic w_tick_free;
    logic w_set_vol;
    logic w_stop_hit;
    logic w_stop_all;

    assign w_accept  = w_in_ready && i_req.valid;
    assign w_idx     = r_cnt[VW-1:0];
    assign w_v_idx   = VW'(r_vsel);
    assign w_v_ok    = 32'(r_vsel) < 32'(VOICES);
    assign w_cnt_end = (r_cnt == CW'(VOICES));

    // Position step and wrap of the voice under the sequencer
    assign w_pos_inc  = LW'(r_pos[w_idx]) + LW'(1);
    assign w_wrap     = (w_pos_inc >= r_len_v[w_idx]);
    assign w_ptr_next = (r_ptr[w_idx] == PTR_LAST) ? '0 : r_ptr[w_idx] + MAW'(1);

    // Zero length plays one frame; over-long sounds saturate
    always_comb begin
        if (r_len == '0) begin
            w_len_fix = LW'(1);
        end else if (r_len > mvpm_pkg::LEN_MAX) begin
            w_len_fix = mvpm_pkg::LEN_MAX;
        end else begin
            w_len_fix = r_len;
        end
    end

    mvpm_addr_mod #(
        .SAMPLE_FRAMES (SAMPLE_FRAMES)
    ) u_addr_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (i_req.address),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    mvpm_sample_mem #(
        .SAMPLE_FRAMES (SAMPLE_FRAMES)
    ) u_sample_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mod_rem),
        .i_wdata ({r_rin, r_lin}),
        .i_re    (w_mem_re),
        .i_raddr (r_ptr[w_idx]),
        .o_rdata (w_mem_rdata)
    );

    mvpm_mac #(
        .VOICES (VOICES)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (w_mac_ctrl),
        .i_frame  (w_mem_rdata),
        .i_volume (r_vol_v[w_idx]),
        .o_left   (w_mix_left),
        .o_right  (w_mix_right)
    );

    // Sequencer: next state and strobes
    always_comb begin
        n_state      = r_state;
        w_in_ready   = 1'b0;
        w_mod_start  = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        w_mac_ctrl   = '0;
        w_out_load   = 1'b0;
        w_cnt_inc    = 1'b0;
        w_claim      = 1'b0;
        w_play_full  = 1'b0;
        w_voice_step = 1'b0;
        w_set_vol    = 1'b0;
        w_stop_hit   = 1'b0;
        w_stop_all   = 1'b0;

        unique case (r_state)
            mvpm_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_req.valid) begin
                    unique case (i_req.op)
                        mvpm_pkg::OP_WRITE, mvpm_pkg::OP_PLAY: begin
                            w_mod_start = 1'b1;
                            n_state     = mvpm_pkg::S_REDUCE;
                        end
                        mvpm_pkg::OP_SET_VOL, mvpm_pkg::OP_STOP, mvpm_pkg::OP_STOP_ALL: begin
                            n_state = mvpm_pkg::S_SIMPLE;
                        end
                        mvpm_pkg::OP_TICK: begin
                            w_mac_ctrl.clear = 1'b1;
                            n_state          = mvpm_pkg::S_TICK_SCAN;
                        end
                        default: begin
                            n_state = mvpm_pkg::S_DONE;
                        end
                    endcase
                end
            end
            mvpm_pkg::S_REDUCE: begin
                if (w_mod_done) begin
                    n_state = (r_op == mvpm_pkg::OP_PLAY) ? mvpm_pkg::S_PLAY_SCAN
                                                          : mvpm_pkg::S_WRITE;
                end
            end
            mvpm_pkg::S_WRITE: begin
                w_mem_we = 1'b1;
                n_state  = mvpm_pkg::S_DONE;
            end
            mvpm_pkg::S_PLAY_SCAN: begin
                if (w_cnt_end) begin
                    w_play_full = 1'b1;
                    n_state     = mvpm_pkg::S_DONE;
                end else if (!r_active[w_idx]) begin
                    w_claim = 1'b1;
                    n_state = mvpm_pkg::S_DONE;
                end else begin
                    w_cnt_inc = 1'b1;
                end
            end
            mvpm_pkg::S_SIMPLE: begin
                unique case (r_op)
                    mvpm_pkg::OP_SET_VOL:  w_set_vol  = w_v_ok;
                    mvpm_pkg::OP_STOP:     w_stop_hit = w_v_ok && r_active[w_v_idx];
                    mvpm_pkg::OP_STOP_ALL: w_stop_all = 1'b1;
                    default: ;
                endcase
                n_state = mvpm_pkg::S_DONE;
            end
            mvpm_pkg::S_TICK_SCAN: begin
                if (w_cnt_end) begin
                    n_state = mvpm_pkg::S_DONE;
                end else if (r_active[w_idx]) begin
                    w_mem_re = 1'b1;
                    n_state  = mvpm_pkg::S_TICK_MUL_L;
                end else begin
                    w_cnt_inc = 1'b1;
                end
            end
            mvpm_pkg::S_TICK_MUL_L: begin
                w_mac_ctrl.mul_en = 1'b1;
                n_state           = mvpm_pkg::S_TICK_MUL_R;
            end
            mvpm_pkg::S_TICK_MUL_R: begin
                // multiply right while the left product accumulates
                w_mac_ctrl.mul_en    = 1'b1;
                w_mac_ctrl.mul_right = 1'b1;
                w_mac_ctrl.acc_en    = 1'b1;
                n_state              = mvpm_pkg::S_TICK_ACC_R;
            end
            mvpm_pkg::S_TICK_ACC_R: begin
                w_mac_ctrl.acc_en    = 1'b1;
                w_mac_ctrl.acc_right = 1'b1;
                w_voice_step         = 1'b1;
                w_cnt_inc            = 1'b1;
                n_state              = mvpm_pkg::S_TICK_SCAN;
            end
            mvpm_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_out_load = 1'b1;
                    n_state    = mvpm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mvpm_pkg::S_IDLE;
            end
        endcase
    end

    assign w_tick_free = w_voice_step && w_wrap && !r_rep_v[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mvpm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_claim) begin
                r_active[w_idx] <= 1'b1;
            end
            if (w_tick_free) begin
                r_active[w_idx] <= 1'b0;
            end
            if (w_stop_hit) begin
                r_active[w_v_idx] <= 1'b0;
            end
            if (w_stop_all) begin
                r_active <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_req.op;
            r_vsel    <= i_req.voice;
            r_len     <= i_req.sound_length;
            r_vol     <= i_req.volume;
            r_rep     <= i_req.repeat_req;
            r_lin     <= i_req.left_in;
            r_rin     <= i_req.right_in;
            r_cnt     <= '0;
            r_fin     <= '0;
            r_handle  <= '0;
            r_nofree  <= 1'b0;
            r_is_tick <= (i_req.op == mvpm_pkg::OP_TICK);
        end
        if (w_cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (w_claim) begin
            r_start[w_idx] <= w_mod_rem;
            r_ptr[w_idx]   <= w_mod_rem;
            r_pos[w_idx]   <= '0;
            r_len_v[w_idx] <= w_len_fix;
            r_vol_v[w_idx] <= r_vol;
            r_rep_v[w_idx] <= r_rep;
            r_handle       <= HW'(r_cnt);
        end
        if (w_play_full) begin
            r_nofree <= 1'b1;
        end
        // Advance the voice; at the end of the sound rewind, and drop one-shots
        if (w_voice_step) begin
            if (w_wrap) begin
                r_pos[w_idx] <= '0;
                r_ptr[w_idx] <= r_start[w_idx];
                if (!r_rep_v[w_idx]) begin
                    r_fin <= r_fin | mvpm_pkg::fin_bit(mvpm_pkg::CNT_MAX_W'(r_cnt));
                end
            end else begin
                r_pos[w_idx] <= w_pos_inc[PSW-1:0];
                r_ptr[w_idx] <= w_ptr_next;
            end
        end
        if (w_set_vol) begin
            r_vol_v[w_v_idx] <= r_vol;
        end
        if (w_stop_hit) begin
            r_fin <= mvpm_pkg::fin_bit(mvpm_pkg::CNT_MAX_W'(r_vsel));
        end
        if (w_stop_all) begin
            r_fin <= MW'(r_active);
        end
        if (w_out_load) begin
            r_out_left   <= r_is_tick ? w_mix_left  : '0;
            r_out_right  <= r_is_tick ? w_mix_right : '0;
            r_out_fin    <= r_fin;
            r_out_handle <= r_handle;
            r_out_nofree <= r_nofree;
        end
    end

    assign i_req.ready         = w_in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.left_out      = r_out_left;
    assign o_rsp.right_out     = r_out_right;
    assign o_rsp.finished_mask = r_out_fin;
    assign o_rsp.handle        = r_out_handle;
    assign o_rsp.no_free_voice = r_out_nofree;

    // A voice reported as finished is no longer playing when the result is ready
    a_fin_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mvpm_pkg::S_DONE) |-> ((r_fin & MW'(r_active)) == '0))
        else $error("finished voice still marked active");

    // A failed play means every slot is taken
    a_nofree_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mvpm_pkg::S_DONE && r_nofree) |-> (&r_active))
        else $error("no_free_voice with a free slot");

    // One command in flight: no accept directly after an accept
    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second command accepted while busy");

    // A failed play carries no mix, no finished bits and no handle
    a_nofree_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.no_free_voice) |->
            (o_rsp.finished_mask == '0 && o_rsp.handle == '0 &&
             o_rsp.left_out == '0 && o_rsp.right_out == '0))
        else $error("no_free_voice word carries other results");

endmodule
